/* rtl/occupancy_grid_ray_update_unit_macros.svh */
// Assertion macros shared by the checker of the occupancy grid ray update unit.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH

`define OGRU_ASSERT_NOW(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

`define OGRU_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ogru_pkg.sv */
// Shared types, codes and constants of the occupancy grid ray update unit.
`timescale 1ns / 1ps
package ogru_pkg;

  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_RAY   = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_VISIT_THR   = 3'd2;
  localparam logic [2:0] CFG_FREE_THR    = 3'd3;
  localparam logic [2:0] CFG_OCC_THR     = 3'd4;

  localparam logic [1:0] CLASS_OCCUPIED  = 2'd0;
  localparam logic [1:0] CLASS_UNCERTAIN = 2'd1;
  localparam logic [1:0] CLASS_FREE      = 2'd2;

  localparam logic [8:0]  RST_GRID_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;
  localparam logic [15:0] RST_VISIT_THR   = 16'd0;
  localparam logic [6:0]  RST_FREE_THR    = 7'd65;
  localparam logic [6:0]  RST_OCC_THR     = 7'd25;

  localparam logic [6:0] PCT_UNKNOWN = 7'd50;
  localparam logic [6:0] PCT_SCALE   = 7'd100;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAY_SETUP,
    ST_RAY_WALK,
    ST_RAY_FLUSH,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_RD_MUL,
    ST_RD_DIV,
    ST_RD_CLASS,
    ST_DONE
  } state_t;

endpackage

/* rtl/ogru_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module ogru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/occupancy_grid_ray_update_unit.sv */
// Top level of the occupancy grid ray update unit.
// Usage: one input word per command on in_valid/in_ready (func selects clear,
// add ray or read cell), one result word per command on out_valid/out_ready.
// Configuration words arrive on cfg_valid/cfg_ready at any time; cfg_ready is
// always high, and they should be written only while the unit is idle.
// The visit and hit counters live in two RAMs of MAX_ROWS*MAX_COLS words.
// Clear writes zero to every word of both RAMs, one RAM word per cycle.
// An add ray walks the line from one end cell to the other, with one visit
// read-modify-write per cycle along the line, with the hit update alongside.
// A read goes through the seven-step percent divider, but a read of an unknown
// cell skips the divider.
// Out-of-grid rays skip the walk and unknown commands go straight to the result.
// One command is worked at a time; the next word is taken as soon as the
// result sits in the output register, even if that result is not yet taken.
// After reset the unit clears every word of both RAMs with in_ready low and
// gives no result for that pass.
// When the receiver stalls, the result holds and the next finished command
// waits in its last state.
`timescale 1ns / 1ps
module occupancy_grid_ray_update_unit #(
  parameter int MAX_COLS   = ogru_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = ogru_pkg::DEF_MAX_ROWS,
  parameter int COUNT_BITS = ogru_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  origin_col,
  input  logic [7:0]  origin_row,
  input  logic [7:0]  target_col,
  input  logic [7:0]  target_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] visit_count,
  output logic [15:0] hit_count,
  output logic [6:0]  occupancy_percent,
  output logic [1:0]  cell_class,
  output logic [8:0]  cells_walked,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = COUNT_BITS;
  localparam int PW    = COUNT_BITS + 7;
  localparam int CMPW  = (CW > 16) ? CW : 16;
  localparam int LC    = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
  localparam int LIMW  = ($clog2(MAX_ROWS + 1) > LC) ? $clog2(MAX_ROWS + 1) : LC;

  ogru_pkg::state_t state, state_next;

  logic [AW-1:0]  clr_addr;
  logic           clr_result;
  logic [1:0]     op_func;
  logic [7:0]     oc, orw, tc, tr;
  logic [8:0]     grid_width, grid_height;
  logic [15:0]    visit_thr;
  logic [6:0]     free_thr, occ_thr;
  logic [7:0]     wx, wy, xend, dx, dy;
  logic           steep, yneg;
  logic signed [10:0] err;
  logic           pend_valid;
  logic [AW-1:0]  pend_addr;
  logic           hit_pend;
  logic           inb;
  logic [CW-1:0]  rv, rhc;
  logic           known;
  logic [PW-1:0]  rem, fnum, ftp, otp;
  logic [6:0]     quo;
  logic [2:0]     div_cnt;
  logic [15:0]    res_visit, res_hit;
  logic [6:0]     res_pct;
  logic [1:0]     res_class;
  logic [8:0]     res_walked;

  logic           visit_we, hit_we;
  logic [AW-1:0]  visit_waddr, visit_raddr, hit_waddr;
  logic [CW-1:0]  visit_wdata, hit_wdata, visit_rdata, hit_rdata;

  logic [LIMW-1:0] cols_used, rows_used;
  logic            tgt_inb, ray_inb;
  logic [AW-1:0]   tgt_addr, walk_addr;
  logic [7:0]      adc, adr, a0, b0, a1, b1, sx0, sy0, sx1, sy1, dx_c, dy_c;
  logic            st_c, swp;
  logic signed [10:0] esum, dy2, dx2;
  logic [CW-1:0]   v_now, h_now;
  logic [PW-1:0]   shifted;
  logic            out_free;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c == {CW{1'b1}}) ? c : c + CW'(1);
  endfunction

  function automatic logic [15:0] sat16(input logic [CW-1:0] c);
    logic [CMPW-1:0] t;
    t = CMPW'(c);
    return (t > CMPW'(16'hFFFF)) ? 16'hFFFF : t[15:0];
  endfunction

  ogru_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_visit_ram (
    .clk(clk), .we(visit_we), .waddr(visit_waddr), .wdata(visit_wdata),
    .raddr(visit_raddr), .rdata(visit_rdata)
  );

  ogru_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_hit_ram (
    .clk(clk), .we(hit_we), .waddr(hit_waddr), .wdata(hit_wdata),
    .raddr(tgt_addr), .rdata(hit_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ogru_pkg::ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign cols_used = (LIMW'(grid_width) < LIMW'(MAX_COLS)) ? LIMW'(grid_width)
                                                           : LIMW'(MAX_COLS);
  assign rows_used = (LIMW'(grid_height) < LIMW'(MAX_ROWS)) ? LIMW'(grid_height)
                                                            : LIMW'(MAX_ROWS);
  assign tgt_inb = (LIMW'(tc) < cols_used) && (LIMW'(tr) < rows_used);
  assign ray_inb = tgt_inb && (LIMW'(oc) < cols_used) && (LIMW'(orw) < rows_used);
  assign tgt_addr  = AW'(AW'(tr) * AW'(MAX_COLS) + AW'(tc));
  assign walk_addr = steep ? AW'(AW'(wx) * AW'(MAX_COLS) + AW'(wy))
                           : AW'(AW'(wy) * AW'(MAX_COLS) + AW'(wx));

  always_comb begin
    adc  = (oc > tc) ? oc - tc : tc - oc;
    adr  = (orw > tr) ? orw - tr : tr - orw;
    st_c = adr > adc;
    a0   = st_c ? orw : oc;
    b0   = st_c ? oc : orw;
    a1   = st_c ? tr : tc;
    b1   = st_c ? tc : tr;
    swp  = a0 > a1;
    sx0  = swp ? a1 : a0;
    sy0  = swp ? b1 : b0;
    sx1  = swp ? a0 : a1;
    sy1  = swp ? b0 : b1;
    dx_c = sx1 - sx0;
    dy_c = (sy1 > sy0) ? sy1 - sy0 : sy0 - sy1;
  end

  assign dy2  = $signed({2'b00, dy, 1'b0});
  assign dx2  = $signed({2'b00, dx, 1'b0});
  assign esum = err + dy2;
  assign v_now   = inb ? visit_rdata : '0;
  assign h_now   = inb ? hit_rdata : '0;
  assign shifted = PW'(rv) << div_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      ogru_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = clr_result ? ogru_pkg::ST_DONE : ogru_pkg::ST_IDLE;
        end
      end
      ogru_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (func)
            ogru_pkg::FN_CLEAR: state_next = ogru_pkg::ST_CLEAR;
            ogru_pkg::FN_RAY:   state_next = ogru_pkg::ST_RAY_SETUP;
            ogru_pkg::FN_READ:  state_next = ogru_pkg::ST_RD_REQ;
            default:            state_next = ogru_pkg::ST_DONE;
          endcase
        end
      end
      ogru_pkg::ST_RAY_SETUP:
        state_next = ray_inb ? ogru_pkg::ST_RAY_WALK : ogru_pkg::ST_DONE;
      ogru_pkg::ST_RAY_WALK:
        if (wx == xend) begin
          state_next = ogru_pkg::ST_RAY_FLUSH;
        end
      ogru_pkg::ST_RAY_FLUSH: state_next = ogru_pkg::ST_DONE;
      ogru_pkg::ST_RD_REQ:    state_next = ogru_pkg::ST_RD_DATA;
      ogru_pkg::ST_RD_DATA:   state_next = ogru_pkg::ST_RD_MUL;
      ogru_pkg::ST_RD_MUL:
        state_next = known ? ogru_pkg::ST_RD_DIV : ogru_pkg::ST_RD_CLASS;
      ogru_pkg::ST_RD_DIV:
        if (div_cnt == 3'd0) begin
          state_next = ogru_pkg::ST_RD_CLASS;
        end
      ogru_pkg::ST_RD_CLASS:  state_next = ogru_pkg::ST_DONE;
      ogru_pkg::ST_DONE:
        if (out_free) begin
          state_next = ogru_pkg::ST_IDLE;
        end
      default: state_next = ogru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    visit_raddr = (state == ogru_pkg::ST_RAY_WALK) ? walk_addr : tgt_addr;
    if (state == ogru_pkg::ST_CLEAR) begin
      visit_we    = 1'b1;
      visit_waddr = clr_addr;
      visit_wdata = '0;
      hit_we      = 1'b1;
      hit_waddr   = clr_addr;
      hit_wdata   = '0;
    end else begin
      visit_we    = pend_valid && ((state == ogru_pkg::ST_RAY_WALK) ||
                                   (state == ogru_pkg::ST_RAY_FLUSH));
      visit_waddr = pend_addr;
      visit_wdata = bump(visit_rdata);
      hit_we      = hit_pend && (state == ogru_pkg::ST_RAY_WALK);
      hit_waddr   = tgt_addr;
      hit_wdata   = bump(hit_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ogru_pkg::ST_CLEAR;
      clr_addr    <= '0;
      clr_result  <= 1'b0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      hit_pend    <= 1'b0;
      grid_width  <= ogru_pkg::RST_GRID_WIDTH;
      grid_height <= ogru_pkg::RST_GRID_HEIGHT;
      visit_thr   <= ogru_pkg::RST_VISIT_THR;
      free_thr    <= ogru_pkg::RST_FREE_THR;
      occ_thr     <= ogru_pkg::RST_OCC_THR;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          ogru_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[8:0];
          ogru_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[8:0];
          ogru_pkg::CFG_VISIT_THR:   visit_thr   <= cfg_data;
          ogru_pkg::CFG_FREE_THR:    free_thr    <= cfg_data[6:0];
          ogru_pkg::CFG_OCC_THR:     occ_thr     <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && (state != ogru_pkg::ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ogru_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        ogru_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_func    <= func;
            oc         <= origin_col;
            orw        <= origin_row;
            tc         <= target_col;
            tr         <= target_row;
            res_visit  <= '0;
            res_hit    <= '0;
            res_pct    <= '0;
            res_class  <= ogru_pkg::CLASS_OCCUPIED;
            res_walked <= '0;
            clr_addr   <= '0;
            clr_result <= 1'b1;
          end
        end
        ogru_pkg::ST_RAY_SETUP: begin
          steep      <= st_c;
          wx         <= sx0;
          wy         <= sy0;
          xend       <= sx1;
          dx         <= dx_c;
          dy         <= dy_c;
          yneg       <= !(sy0 < sy1);
          err        <= '0;
          hit_pend   <= ray_inb;
          pend_valid <= 1'b0;
          res_walked <= ray_inb ? 9'(dx_c) + 9'd1 : 9'd0;
        end
        ogru_pkg::ST_RAY_WALK: begin
          pend_valid <= 1'b1;
          pend_addr  <= walk_addr;
          hit_pend   <= 1'b0;
          wx         <= wx + 8'd1;
          if (esum >= $signed({3'b000, dx})) begin
            wy  <= yneg ? wy - 8'd1 : wy + 8'd1;
            err <= esum - dx2;
          end else begin
            err <= esum;
          end
        end
        ogru_pkg::ST_RAY_FLUSH: begin
          pend_valid <= 1'b0;
        end
        ogru_pkg::ST_RD_REQ: begin
          inb <= tgt_inb;
        end
        ogru_pkg::ST_RD_DATA: begin
          res_visit <= sat16(v_now);
          res_hit   <= sat16(h_now);
          rv        <= v_now;
          rhc       <= (h_now > v_now) ? v_now : h_now;
          known     <= CMPW'(v_now) > CMPW'(visit_thr);
        end
        ogru_pkg::ST_RD_MUL: begin
          rem     <= PW'(rhc) * PW'(ogru_pkg::PCT_SCALE);
          fnum    <= known ? PW'(rv - rhc) * PW'(ogru_pkg::PCT_SCALE)
                           : PW'(ogru_pkg::PCT_UNKNOWN);
          ftp     <= known ? PW'(rv) * PW'(free_thr) : PW'(free_thr);
          otp     <= known ? PW'(rv) * PW'(occ_thr) : PW'(occ_thr);
          div_cnt <= 3'd6;
          quo     <= '0;
        end
        ogru_pkg::ST_RD_DIV: begin
          if (rem >= shifted) begin
            rem          <= rem - shifted;
            quo[div_cnt] <= 1'b1;
          end
          div_cnt <= div_cnt - 3'd1;
        end
        ogru_pkg::ST_RD_CLASS: begin
          res_pct <= known ? quo : ogru_pkg::PCT_UNKNOWN;
          if (fnum >= ftp) begin
            res_class <= ogru_pkg::CLASS_FREE;
          end else if (fnum >= otp) begin
            res_class <= ogru_pkg::CLASS_UNCERTAIN;
          end else begin
            res_class <= ogru_pkg::CLASS_OCCUPIED;
          end
        end
        ogru_pkg::ST_DONE: begin
          if (out_free) begin
            visit_count       <= res_visit;
            hit_count         <= res_hit;
            occupancy_percent <= res_pct;
            cell_class        <= res_class;
            cells_walked      <= (op_func == ogru_pkg::FN_RAY) ? res_walked : 9'd0;
            out_valid         <= 1'b1;
            clr_result        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ogru_checker.sv */
// Port-level checker of the occupancy grid ray update unit and its bind.
`timescale 1ns / 1ps
`include "occupancy_grid_ray_update_unit_macros.svh"
module ogru_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] visit_count,
  input logic [15:0] hit_count,
  input logic [6:0]  occupancy_percent,
  input logic [1:0]  cell_class,
  input logic [8:0]  cells_walked
);

  `OGRU_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result word dropped")
  `OGRU_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(cell_class) && $stable(visit_count), "stalled result word changed")
  `OGRU_ASSERT_NOW(a_pct_range, clk, rst, !out_valid || (occupancy_percent <= 7'd100 && cell_class != 2'd3), "percent or class out of range")
  `OGRU_ASSERT_NOW(a_ray_zero, clk, rst, !out_valid || cells_walked == 9'd0 || (visit_count == 16'd0 && hit_count == 16'd0 && occupancy_percent == 7'd0 && cell_class == 2'd0), "ray word carries cell fields")

endmodule

bind occupancy_grid_ray_update_unit ogru_checker u_ogru_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .visit_count(visit_count),
  .hit_count(hit_count),
  .occupancy_percent(occupancy_percent),
  .cell_class(cell_class),
  .cells_walked(cells_walked)
);
